[rtl/mtn_pkg.sv]
// ---------------------------------------------------------------------------
// mtn_pkg: shared types and constants for the MAC-to-node map engine
// Holds the status codes, the field widths and the table request struct
// that passes between the sequencer and the address table.
// ---------------------------------------------------------------------------
`default_nettype none

package mtn_pkg;

    // Field widths.
    localparam int MAC_W   = 48;
    localparam int SLOT_W  = 7;
    localparam int NODE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int STAT_W  = 3;
    localparam int TBL_DEPTH = 1 << SLOT_W;

    // Status codes of a result.
    localparam logic [STAT_W-1:0] ST_ACCEPTED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_WRONG_IFACE = 3'd1;
    localparam logic [STAT_W-1:0] ST_SHORT       = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL        = 3'd3;
    localparam logic [STAT_W-1:0] ST_TAGGED      = 3'd4;
    localparam logic [STAT_W-1:0] ST_TX_OK       = 3'd5;
    localparam logic [STAT_W-1:0] ST_NO_GW       = 3'd6;

    // Header size adjustment and the slack allowed for the Ethernet header.
    localparam logic [LEN_W-1:0] HDR_ADJ   = 16'd24;
    localparam logic [LEN_W:0]   ETH_SLACK = 17'd14;

    // Broadcast address held in the entry just past the probed slots.
    localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

    // One access to the address table: a read and a write request.
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
    } t_tbl_req;

endpackage

`default_nettype wire

[rtl/mtn_table.sv]
// ---------------------------------------------------------------------------
// mtn_table: address table memory
// A 128 x 48 memory with one write and one registered read port. Valid
// bits, cleared by reset, stand in for the reset contents: an entry never
// written reads as zero, or as the broadcast address at the entry just
// past the probed slots.
// ---------------------------------------------------------------------------
`default_nettype none

module mtn_table #(
    parameter int TABLE_ENTRIES = 127
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  mtn_pkg::t_tbl_req      i_req,
    input  wire  [mtn_pkg::MAC_W-1:0]    i_wr_data,
    output logic [mtn_pkg::MAC_W-1:0]    o_rd_data
);
    import mtn_pkg::*;

    localparam logic [SLOT_W-1:0] LP_BCAST_SLOT = SLOT_W'(TABLE_ENTRIES);

    logic [MAC_W-1:0]     r_mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] r_valid;
    logic [MAC_W-1:0]     r_rd_raw;
    logic                 r_rd_vld;
    logic [SLOT_W-1:0]    r_rd_addr;

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_raw  <= r_mem[i_req.rd_addr];
            r_rd_vld  <= r_valid[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    // Valid bits, cleared at once by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // An unwritten entry reads as its reset contents.
    always_comb begin
        if (r_rd_vld) begin
            o_rd_data = r_rd_raw;
        end else if (r_rd_addr == LP_BCAST_SLOT) begin
            o_rd_data = MAC_BCAST;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

`default_nettype wire

[rtl/mac_to_node_map_engine_core.sv]
// ---------------------------------------------------------------------------
// mac_to_node_map_engine_core: MAC-to-node map engine
// Maps Ethernet source addresses to node numbers by linear probing of an
// address table, learns the gateway address, and resolves transmit
// destination nodes back to Ethernet addresses.
// ---------------------------------------------------------------------------
//
// Channel   Ports                                         Handshake
// request   i_kind i_iface i_src_mac i_header_src_node    i_start & !o_busy
//           i_length i_frame_total i_dest_node
// result    o_status o_node o_mac_out o_length_out        o_valid, one cycle
//
// Rejected receives, tagged nodes and gateway transmits register the result
// in the decode state; a mapped transmit reads the table and registers it in
// the transmit read state. A mapping takes at most TABLE_ENTRIES probes,
// and the single table read port checks one slot per cycle.
// Reset clears the table valid bits and the gateway at once; there is
// no clearing pass. The receiver cannot stall: o_busy drops in the cycle
// the result is shown, so the next request may be taken then.
// ---------------------------------------------------------------------------
`default_nettype none

module mac_to_node_map_engine_core #(
    parameter int TABLE_ENTRIES = 127
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    output logic                          o_busy,
    input  wire                           i_kind,
    input  wire  [3:0]                    i_iface,
    input  wire  [mtn_pkg::MAC_W-1:0]     i_src_mac,
    input  wire  [mtn_pkg::NODE_W-1:0]    i_header_src_node,
    input  wire  [mtn_pkg::LEN_W-1:0]     i_length,
    input  wire  [mtn_pkg::LEN_W-1:0]     i_frame_total,
    input  wire  [mtn_pkg::NODE_W-1:0]    i_dest_node,
    output logic                          o_valid,
    output logic [mtn_pkg::STAT_W-1:0]    o_status,
    output logic [mtn_pkg::NODE_W-1:0]    o_node,
    output logic [mtn_pkg::MAC_W-1:0]     o_mac_out,
    output logic [mtn_pkg::LEN_W-1:0]     o_length_out
);
    import mtn_pkg::*;

    localparam logic [NODE_W-1:0] LP_ENTRIES = NODE_W'(TABLE_ENTRIES);
    localparam logic [NODE_W-1:0] LP_LAST    = NODE_W'(TABLE_ENTRIES - 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_PROBE  = 2'd2;
    localparam logic [1:0] S_TXRD   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic              r_valid, n_valid;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_rd_slot, n_rd_slot;
    logic              r_rd_valid, n_rd_valid;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic [MAC_W-1:0]  r_gw, n_gw;

    // Captured request.
    logic              r_kind;
    logic [3:0]        r_iface;
    logic [MAC_W-1:0]  r_src_mac;
    logic [NODE_W-1:0] r_hdr_node;
    logic [LEN_W-1:0]  r_length;
    logic [LEN_W-1:0]  r_frame_total;
    logic [NODE_W-1:0] r_dest;

    // Result registers.
    logic [STAT_W-1:0] r_status, n_status;
    logic [NODE_W-1:0] r_node, n_node;
    logic [MAC_W-1:0]  r_mac, n_mac;
    logic [LEN_W-1:0]  r_len, n_len;

    t_tbl_req          tbl_req;
    logic [MAC_W-1:0]  tbl_rd_data;

    logic              accept;
    logic              is_short;
    logic [SLOT_W-1:0] home_slot;
    logic [SLOT_W-1:0] next_slot;
    logic              hit;
    logic              empty;

    mtn_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (tbl_req),
        .i_wr_data (r_src_mac),
        .o_rd_data (tbl_rd_data)
    );

    assign accept = i_start && (r_state == S_IDLE);

    // Receive checks and slot arithmetic.
    assign is_short  = {1'b0, r_length} > ({1'b0, r_frame_total} + ETH_SLACK);
    assign home_slot = ({1'b0, r_src_mac[SLOT_W-1:0]} >= LP_ENTRIES) ?
                       '0 : r_src_mac[SLOT_W-1:0];
    assign next_slot = ({1'b0, r_slot} + NODE_W'(1) >= LP_ENTRIES) ?
                       '0 : r_slot + SLOT_W'(1);
    assign hit   = (tbl_rd_data == r_src_mac);
    assign empty = (tbl_rd_data == '0);

    // Sequencer: decode, probe one slot per cycle, or read for transmit.
    always_comb begin
        n_state    = r_state;
        n_valid    = 1'b0;
        n_slot     = r_slot;
        n_rd_slot  = r_rd_slot;
        n_rd_valid = r_rd_valid;
        n_cnt      = r_cnt;
        n_gw       = r_gw;
        n_status   = r_status;
        n_node     = r_node;
        n_mac      = r_mac;
        n_len      = r_len;
        tbl_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_kind) begin
                    if (r_dest[NODE_W-1]) begin
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = r_dest[SLOT_W-1:0];
                        n_state         = S_TXRD;
                    end else begin
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                        n_node   = r_dest;
                        n_len    = r_length + HDR_ADJ;
                        n_mac    = r_gw;
                        n_status = (r_gw != '0) ? ST_TX_OK : ST_NO_GW;
                    end
                end else if (r_iface != 4'd0 || is_short ||
                             r_hdr_node[NODE_W-1]) begin
                    // Rejected receive: zeros and no state change.
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_node  = '0;
                    n_len   = '0;
                    n_mac   = '0;
                    if (r_iface != 4'd0) begin
                        n_status = ST_WRONG_IFACE;
                    end else if (is_short) begin
                        n_status = ST_SHORT;
                    end else if (r_hdr_node == '0) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_TAGGED;
                    end
                    if (r_iface == 4'd0 && !is_short && r_hdr_node == '0) begin
                        // Plain node: not a rejection, go map it.
                        n_state    = S_PROBE;
                        n_valid    = 1'b0;
                        n_slot     = home_slot;
                        n_cnt      = '0;
                        n_rd_valid = 1'b0;
                    end
                end else if (r_hdr_node == '0) begin
                    n_state    = S_PROBE;
                    n_slot     = home_slot;
                    n_cnt      = '0;
                    n_rd_valid = 1'b0;
                end else begin
                    // Gateway-tagged node passes through and teaches the gateway if none is known.
                    if (r_gw == '0) begin
                        n_gw = r_src_mac;
                    end
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_ACCEPTED;
                    n_node   = r_hdr_node;
                    n_len    = r_length - HDR_ADJ;
                    n_mac    = '0;
                end
            end
            S_PROBE: begin
                // Issue the next slot while the previous one is compared.
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = r_slot;
                n_slot          = next_slot;
                n_rd_slot       = r_slot;
                n_rd_valid      = 1'b1;
                if (r_rd_valid) begin
                    if (hit || empty) begin
                        if (!hit) begin
                            tbl_req.wr_en   = 1'b1;
                            tbl_req.wr_addr = r_rd_slot;
                        end
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                        n_status = ST_ACCEPTED;
                        n_node   = {1'b1, r_rd_slot};
                        n_len    = r_length - HDR_ADJ;
                        n_mac    = '0;
                    end else if ({1'b0, r_cnt} == LP_LAST) begin
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                        n_status = ST_FULL;
                        n_node   = '0;
                        n_len    = '0;
                        n_mac    = '0;
                    end else begin
                        n_cnt = r_cnt + SLOT_W'(1);
                    end
                end
            end
            S_TXRD: begin
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_status = ST_TX_OK;
                n_node   = r_dest;
                n_len    = r_length + HDR_ADJ;
                n_mac    = tbl_rd_data;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= 1'b0;
            r_slot     <= '0;
            r_rd_slot  <= '0;
            r_rd_valid <= 1'b0;
            r_cnt      <= '0;
            r_gw       <= '0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_slot     <= n_slot;
            r_rd_slot  <= n_rd_slot;
            r_rd_valid <= n_rd_valid;
            r_cnt      <= n_cnt;
            r_gw       <= n_gw;
        end
    end

    // Request capture and result registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind        <= i_kind;
            r_iface       <= i_iface;
            r_src_mac     <= i_src_mac;
            r_hdr_node    <= i_header_src_node;
            r_length      <= i_length;
            r_frame_total <= i_frame_total;
            r_dest        <= i_dest_node;
        end
        r_status <= n_status;
        r_node   <= n_node;
        r_mac    <= n_mac;
        r_len    <= n_len;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_node       = r_node;
    assign o_mac_out    = r_mac;
    assign o_length_out = r_len;

    // Every request passes through the decode state first, so strobes never abut.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobes in consecutive cycles");

    // A taken request makes the engine busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("engine not busy after a request was taken");

    // The probe count stays within the table.
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> ({1'b0, r_cnt} < LP_ENTRIES))
        else $error("probe count ran past the table");

    // A mapped node always names a probed slot.
    a_node_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_ACCEPTED && o_node[NODE_W-1]) |->
        ({1'b0, o_node[SLOT_W-1:0]} < LP_ENTRIES))
        else $error("mapped node outside the table");

    // Rejected receives return all-zero fields.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_WRONG_IFACE || o_status == ST_SHORT ||
                     o_status == ST_FULL || o_status == ST_TAGGED)) |->
        (o_node == '0 && o_length_out == '0 && o_mac_out == '0))
        else $error("rejected receive with nonzero fields");

endmodule

`default_nettype wire

[bench/mac_to_node_map_checker.sv]
// ---------------------------------------------------------------------------
// mac_to_node_map_checker: result checker for the MAC-to-node map engine
// Watches the request and result channels, keeps its own copy of the
// address table and the gateway, predicts one result per accepted request
// and compares every result field by field against the oldest prediction.
// ---------------------------------------------------------------------------

package mtn_tb_pkg;

    // Request kinds.
    localparam logic KIND_RX = 1'b0;
    localparam logic KIND_TX = 1'b1;

    // Node number bit that marks a mapped Ethernet node.
    localparam logic [7:0] NODE_ETHER = 8'h80;

endpackage

module mac_to_node_map_checker #(
    parameter int TABLE_ENTRIES = 127
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_kind,
    input  logic [3:0]                    i_iface,
    input  logic [mtn_pkg::MAC_W-1:0]     i_src_mac,
    input  logic [mtn_pkg::NODE_W-1:0]    i_header_src_node,
    input  logic [mtn_pkg::LEN_W-1:0]     i_length,
    input  logic [mtn_pkg::LEN_W-1:0]     i_frame_total,
    input  logic [mtn_pkg::NODE_W-1:0]    i_dest_node,
    input  logic                          i_valid,
    input  logic [mtn_pkg::STAT_W-1:0]    i_status,
    input  logic [mtn_pkg::NODE_W-1:0]    i_node,
    input  logic [mtn_pkg::MAC_W-1:0]     i_mac_out,
    input  logic [mtn_pkg::LEN_W-1:0]     i_length_out,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mtn_pkg::*;
    import mtn_tb_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [NODE_W-1:0] node;
        logic [MAC_W-1:0]  mac;
        logic [LEN_W-1:0]  len;
    } t_node_result;

    // Shadow copy of the engine state.
    logic [MAC_W-1:0] node_addr_table [TBL_DEPTH];
    logic [MAC_W-1:0] gateway_mac;

    t_node_result node_results_due [$];
    int           mismatch_count;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        mismatch_count = 0;
    end

    // Works out the result of one request and updates the shadow state.
    function automatic t_node_result predict_node_result(
        input logic              kind,
        input logic [3:0]        iface,
        input logic [MAC_W-1:0]  src,
        input logic [NODE_W-1:0] hdr,
        input logic [LEN_W-1:0]  len,
        input logic [LEN_W-1:0]  ftot,
        input logic [NODE_W-1:0] dest
    );
        t_node_result res;
        int           slot;
        int           probe;
        bit           placed;

        res = '0;
        if (kind == KIND_TX) begin
            res.node = dest;
            res.len  = len + HDR_ADJ;
            if ((dest & NODE_ETHER) != '0) begin
                res.mac    = node_addr_table[dest[SLOT_W-1:0]];
                res.status = ST_TX_OK;
            end else if (gateway_mac != '0) begin
                res.mac    = gateway_mac;
                res.status = ST_TX_OK;
            end else begin
                res.status = ST_NO_GW;
            end
        end else if (iface != '0) begin
            res.status = ST_WRONG_IFACE;
        end else if ({1'b0, len} > {1'b0, ftot} + ETH_SLACK) begin
            res.status = ST_SHORT;
        end else if (hdr == '0) begin
            // Linear probe from the home slot; a zero address matches an empty slot.
            slot = int'(src[SLOT_W-1:0]);
            if (slot >= TABLE_ENTRIES) begin
                slot = 0;
            end
            placed = 1'b0;
            for (probe = 0; probe < TABLE_ENTRIES && !placed; probe++) begin
                if (node_addr_table[slot] == src || node_addr_table[slot] == '0) begin
                    node_addr_table[slot] = src;
                    placed = 1'b1;
                end else begin
                    slot++;
                    if (slot >= TABLE_ENTRIES) begin
                        slot = 0;
                    end
                end
            end
            if (placed) begin
                res.status = ST_ACCEPTED;
                res.node   = NODE_ETHER | NODE_W'(slot);
                res.len    = len - HDR_ADJ;
            end else begin
                res.status = ST_FULL;
            end
        end else if ((hdr & NODE_ETHER) != '0) begin
            res.status = ST_TAGGED;
        end else begin
            // A tagged node teaches the gateway only while none is known.
            if (gateway_mac == '0) begin
                gateway_mac = src;
            end
            res.status = ST_ACCEPTED;
            res.node   = hdr;
            res.len    = len - HDR_ADJ;
        end
        return res;
    endfunction

    function automatic void compare_field(
        input string            field,
        input logic [MAC_W-1:0] want,
        input logic [MAC_W-1:0] got
    );
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare results first, then record the request taken at the same edge.
    always @(posedge i_clk) begin
        t_node_result due;

        if (!i_rst_n) begin
            foreach (node_addr_table[i]) begin
                node_addr_table[i] = '0;
            end
            node_addr_table[TABLE_ENTRIES % TBL_DEPTH] = MAC_BCAST;
            gateway_mac = '0;
            node_results_due.delete();
        end else begin
            if (i_valid) begin
                if (node_results_due.size() == 0) begin
                    $error("result with no request outstanding: status %0d node 0x%0h",
                           i_status, i_node);
                    mismatch_count++;
                end else begin
                    due = node_results_due.pop_front();
                    compare_field("status", MAC_W'(due.status), MAC_W'(i_status));
                    compare_field("node", MAC_W'(due.node), MAC_W'(i_node));
                    compare_field("mac_out", due.mac, i_mac_out);
                    compare_field("length_out", MAC_W'(due.len), MAC_W'(i_length_out));
                end
            end
            if (i_start && !i_busy) begin
                node_results_due.push_back(predict_node_result(
                    i_kind, i_iface, i_src_mac, i_header_src_node,
                    i_length, i_frame_total, i_dest_node));
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= node_results_due.size();
    end

endmodule

[bench/tb_mac_to_node_map_engine_core.sv]
// ---------------------------------------------------------------------------
// tb_mac_to_node_map_engine_core: testbench for the MAC-to-node map engine
// Drives a directed set of requests covering the corner cases, then about
// two thousand random ones that fill the address table gradually, with the
// sender idling at different rates. A checker beside the engine predicts
// and compares every result.
// ---------------------------------------------------------------------------

module tb_mac_to_node_map_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mtn_pkg::*;
    import mtn_tb_pkg::*;

    localparam int TABLE_ENTRIES = 127;
    localparam int RANDOM_REQUESTS = 2000;
    localparam int CYCLE_LIMIT = 3_000_000;

    // Sender idle percentage for each quarter of the random part.
    localparam int IDLE_PCT [4] = '{0, 72, 0, 37};

    typedef struct packed {
        logic              kind;
        logic [3:0]        iface;
        logic [MAC_W-1:0]  src_mac;
        logic [NODE_W-1:0] hdr_node;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  ftot;
        logic [NODE_W-1:0] dest;
    } t_request;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              req_start       = 1'b0;
    logic              req_kind        = KIND_RX;
    logic [3:0]        req_iface       = '0;
    logic [MAC_W-1:0]  req_src_mac     = '0;
    logic [NODE_W-1:0] req_hdr_node    = '0;
    logic [LEN_W-1:0]  req_length      = '0;
    logic [LEN_W-1:0]  req_frame_total = '0;
    logic [NODE_W-1:0] req_dest_node   = '0;
    logic              busy;
    logic              res_valid;
    logic [STAT_W-1:0] res_status;
    logic [NODE_W-1:0] res_node;
    logic [MAC_W-1:0]  res_mac;
    logic [LEN_W-1:0]  res_length;
    int                fail_count;
    int                pending;
    int                cycle_count;

    // Addresses already sent for mapping, reused to hit existing entries.
    logic [MAC_W-1:0]  mapped_macs [$];

    always #5 i_clk = ~i_clk;

    mac_to_node_map_engine_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (req_start),
        .o_busy           (busy),
        .i_kind           (req_kind),
        .i_iface          (req_iface),
        .i_src_mac        (req_src_mac),
        .i_header_src_node(req_hdr_node),
        .i_length         (req_length),
        .i_frame_total    (req_frame_total),
        .i_dest_node      (req_dest_node),
        .o_valid          (res_valid),
        .o_status         (res_status),
        .o_node           (res_node),
        .o_mac_out        (res_mac),
        .o_length_out     (res_length)
    );

    mac_to_node_map_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (req_start),
        .i_busy           (busy),
        .i_kind           (req_kind),
        .i_iface          (req_iface),
        .i_src_mac        (req_src_mac),
        .i_header_src_node(req_hdr_node),
        .i_length         (req_length),
        .i_frame_total    (req_frame_total),
        .i_dest_node      (req_dest_node),
        .i_valid          (res_valid),
        .i_status         (res_status),
        .i_node           (res_node),
        .i_mac_out        (res_mac),
        .i_length_out     (res_length),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    function automatic logic [MAC_W-1:0] random_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Receive request; the destination node is ignored, so it is random.
    function automatic t_request rx_request(
        input logic [3:0]        iface,
        input logic [MAC_W-1:0]  src,
        input logic [NODE_W-1:0] hdr,
        input logic [LEN_W-1:0]  len,
        input logic [LEN_W-1:0]  ftot
    );
        t_request rq;

        rq.kind     = KIND_RX;
        rq.iface    = iface;
        rq.src_mac  = src;
        rq.hdr_node = hdr;
        rq.len      = len;
        rq.ftot     = ftot;
        rq.dest     = NODE_W'($urandom);
        return rq;
    endfunction

    // Transmit request; the receive-side fields are ignored, so they are random.
    function automatic t_request tx_request(
        input logic [NODE_W-1:0] dest,
        input logic [LEN_W-1:0]  len
    );
        t_request rq;

        rq.kind     = KIND_TX;
        rq.iface    = 4'($urandom);
        rq.src_mac  = random_mac();
        rq.hdr_node = NODE_W'($urandom);
        rq.len      = len;
        rq.ftot     = LEN_W'($urandom);
        rq.dest     = dest;
        return rq;
    endfunction

    // Present one request and hold it until the engine takes it.
    task automatic issue_request(input t_request rq);
        req_start       <= 1'b1;
        req_kind        <= rq.kind;
        req_iface       <= rq.iface;
        req_src_mac     <= rq.src_mac;
        req_hdr_node    <= rq.hdr_node;
        req_length      <= rq.len;
        req_frame_total <= rq.ftot;
        req_dest_node   <= rq.dest;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Random sender gap, short or now and then long, taken with the given percentage.
    task automatic idle_sender(input int pct);
        int gap;

        gap = ($urandom_range(7) == 0) ? $urandom_range(20, 140) : $urandom_range(1, 4);
        if ($urandom_range(99) < pct) begin
            req_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Run limit.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_request         directed [$];
        t_request         rq;
        logic [MAC_W-1:0] src;
        logic [LEN_W-1:0] ftot;
        int               len_cap;
        int               roll;
        int               pick;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Transmit before any gateway is known, then a zero gateway source.
        directed.push_back(tx_request(8'h00, 16'h0000));
        directed.push_back(tx_request(8'h7F, 16'hFFFF));
        directed.push_back(rx_request(4'h0, '0, 8'h05, 16'd40, 16'd100));
        directed.push_back(tx_request(8'h01, 16'd10));
        // Broadcast entry and an empty entry.
        directed.push_back(tx_request(8'hFF, 16'd64));
        directed.push_back(tx_request(8'h80, 16'd64));
        // Interface, then length, then source node, in that order of checking.
        directed.push_back(rx_request(4'hF, random_mac(), 8'h00, 16'd10, 16'd100));
        directed.push_back(rx_request(4'h1, random_mac(), 8'h80, 16'hFFFF, 16'h0000));
        directed.push_back(rx_request(4'h0, random_mac(), 8'h00, 16'hFFFF, 16'h0000));
        directed.push_back(rx_request(4'h0, random_mac(), 8'h00, 16'd115, 16'd100));
        directed.push_back(rx_request(4'h0, random_mac(), 8'h80, 16'hFFFF, 16'hFFF0));
        // Zero source address at the top of the length range, no overflow.
        directed.push_back(rx_request(4'h0, '0, 8'h00, 16'hFFFF, 16'hFFFF));
        directed.push_back(rx_request(4'h0, random_mac(), 8'h80, 16'd114, 16'd100));
        directed.push_back(rx_request(4'h0, random_mac(), 8'hFF, 16'd0, 16'd0));
        // Gateway learned once, then used.
        directed.push_back(rx_request(4'h0, MAC_BCAST, 8'h7F, 16'd0, 16'd0));
        directed.push_back(rx_request(4'h0, 48'h0123_4567_89AB, 8'h01, 16'd24, 16'd10));
        directed.push_back(tx_request(8'h00, 16'd100));
        // Home slot wrap, zero address probing, collisions across the end.
        directed.push_back(rx_request(4'h0, MAC_BCAST, 8'h00, 16'd60, 16'd60));
        directed.push_back(rx_request(4'h0, '0, 8'h00, 16'd60, 16'd60));
        directed.push_back(rx_request(4'h0, 48'h0A0B_0C0D_0E7E, 8'h00, 16'd30, 16'd20));
        directed.push_back(rx_request(4'h0, 48'h1A1B_1C1D_1EFE, 8'h00, 16'd30, 16'd20));
        directed.push_back(rx_request(4'h0, 48'h0A0B_0C0D_0E7E, 8'h00, 16'd30, 16'd20));
        directed.push_back(tx_request(8'hFE, 16'hFFE8));
        directed.push_back(tx_request(8'h81, 16'd1));
        directed.push_back(tx_request(8'h7F, 16'd0));
        mapped_macs = '{MAC_BCAST, 48'h0A0B_0C0D_0E7E, 48'h1A1B_1C1D_1EFE};

        foreach (directed[i]) begin
            issue_request(directed[i]);
        end

        // Random part: mostly well-formed receives, the table filling slowly.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            ftot    = LEN_W'($urandom);
            len_cap = (int'(ftot) + 14 > 65535) ? 65535 : int'(ftot) + 14;
            roll    = $urandom_range(99);
            if (roll < 55) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    src = $urandom_range(1) ? '0 : MAC_BCAST;
                end else if (pick < 20 || mapped_macs.size() == 0) begin
                    src = random_mac();
                    if ($urandom_range(1)) begin
                        src[SLOT_W-1:0] = SLOT_W'($urandom_range(120, 127));
                    end
                    mapped_macs.push_back(src);
                end else begin
                    src = mapped_macs[$urandom_range(mapped_macs.size() - 1)];
                end
                rq = rx_request(4'h0, src, 8'h00, LEN_W'($urandom_range(len_cap)), ftot);
            end else if (roll < 65) begin
                rq = rx_request(4'h0, random_mac(), NODE_W'($urandom_range(1, 255)),
                                LEN_W'($urandom_range(len_cap)), ftot);
            end else if (roll < 85) begin
                rq = tx_request(NODE_W'($urandom), LEN_W'($urandom));
            end else begin
                // Noise: every field random, half transmits and mostly rejected receives.
                rq = rx_request(4'($urandom), random_mac(), NODE_W'($urandom),
                                LEN_W'($urandom), ftot);
                rq.kind = 1'($urandom);
            end
            issue_request(rq);
            idle_sender(IDLE_PCT[n * 4 / RANDOM_REQUESTS]);
        end

        // Drain, then wait longer than a full-table probe for stray results.
        req_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (TABLE_ENTRIES + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
